FILE: hw/rtl/cdqm_pkg.sv
package cdqm_pkg;

  localparam int unsigned DEPTH       = 32;
  localparam int unsigned VALUE_RANGE = 100;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned VAL_W    = 7;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned TALLY_W  = 6;
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned TALLY_AW = $clog2(VALUE_RANGE);

  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_INS_HEAD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_TAIL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REM_HEAD = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REM_TAIL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DUMP     = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_FOUND   = 3'd0;
  localparam logic [STAT_W-1:0] STAT_MISSING = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ELEMENT = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  item_value;
  } in_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  out_value;
    logic              last;
  } out_beat_t;

  typedef enum logic [2:0] {
    CH_HOLD,
    CH_PUSH_HEAD,
    CH_PUSH_TAIL,
    CH_POP_HEAD,
    CH_ROTATE
  } chain_op_e;

  typedef struct packed {
    chain_op_e        op;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
  } chain_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT_UPD,
    ST_SEARCH,
    ST_EMIT,
    ST_DUMP
  } state_e;

endpackage

FILE: hw/rtl/cdqm_cell.sv
module cdqm_cell (
  input  logic                       clk_i,
  input  cdqm_pkg::chain_ctrl_t      ctrl_i,
  input  logic [cdqm_pkg::IDX_W-1:0] idx_i,
  input  logic [cdqm_pkg::VAL_W-1:0] prev_i,
  input  logic [cdqm_pkg::VAL_W-1:0] next_i,
  input  logic [cdqm_pkg::VAL_W-1:0] head_i,
  output logic [cdqm_pkg::VAL_W-1:0] val_o
);
  import cdqm_pkg::*;

  logic [VAL_W-1:0] val_q, val_d;
  logic             at_count;
  logic             at_tail;

  assign at_count = (CNT_W'(idx_i) == ctrl_i.count);
  assign at_tail  = ((CNT_W'(idx_i) + CNT_W'(1)) == ctrl_i.count);

  always_comb begin
    val_d = val_q;
    unique case (ctrl_i.op)
      CH_PUSH_HEAD: val_d = prev_i;
      CH_PUSH_TAIL: if (at_count) val_d = ctrl_i.value;
      CH_POP_HEAD:  val_d = next_i;
      // tail cell wraps around to the head so the occupied range recirculates
      CH_ROTATE:    val_d = at_tail ? head_i : next_i;
      default:      val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

FILE: hw/rtl/cdqm_tally.sv
module cdqm_tally (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [cdqm_pkg::TALLY_AW-1:0] rd_addr_i,
  output logic [cdqm_pkg::TALLY_W-1:0]  rd_data_o,
  input  logic                          wr_en_i,
  input  logic [cdqm_pkg::TALLY_AW-1:0] wr_addr_i,
  input  logic [cdqm_pkg::TALLY_W-1:0]  wr_data_i
);
  import cdqm_pkg::*;

  logic [TALLY_W-1:0]     mem_q [VALUE_RANGE];
  logic [VALUE_RANGE-1:0] valid_q;
  logic [TALLY_W-1:0]     rdata_q;
  logic                   rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // an entry never written since reset reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en_i) valid_q[wr_addr_i] <= 1'b1;
      if (rd_en_i) rvalid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en_i && wr_en_i))
    else $error("tally read and write in the same cycle");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> (wr_addr_i < VALUE_RANGE))
    else $error("tally write out of range");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> (rd_addr_i < VALUE_RANGE))
    else $error("tally read out of range");

endmodule

FILE: hw/rtl/circular_deque_with_membership.sv
// Double-ended queue of small values with a per-value occurrence table.
//
// in channel  (in_valid_i/in_ready_o, in_data_i): one request per beat:
//   insert head/tail, remove head/tail, search, dump.
// out channel (out_valid_o/out_ready_i, out_data_o): result beats, last set
//   on the final beat of each request.
// Storage is a row of DEPTH cells that shift as one; cell 0 is the head.
// The occurrence table is a VALUE_RANGE-entry RAM with a registered read.
// Steps from acceptance until the next request is taken:
//   insert / remove  table read, then table write
//   search           table read, then the result beat is registered
//   full / empty     no table access; the result beat is registered
//   dump             one element beat per cycle while the output is free,
//                    by rotating the occupied cells once around
// Unused kinds, out-of-range inserts and removes on an empty queue give no beat.
// A request is taken only while the control is idle; a result beat waiting
// in the output register does not block acceptance, but any further beat
// stalls until the receiver takes the one held. Reset empties the queue and
// clears the table's valid bits at once; no clearing pass is needed.
module circular_deque_with_membership (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cdqm_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cdqm_pkg::out_beat_t out_data_o
);
  import cdqm_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    dump_idx_q, dump_idx_d;
  logic [STAT_W-1:0]   res_status_q, res_status_d;
  logic                cnt_inc_q, cnt_inc_d;
  logic [TALLY_AW-1:0] cnt_addr_q, cnt_addr_d;
  logic                out_valid_q;
  out_beat_t           out_data_q, out_next;
  logic                out_load;
  logic                out_free;

  chain_ctrl_t         chain_ctrl;
  chain_op_e           chain_op;
  logic [VAL_W-1:0]    cells [DEPTH];
  logic [VAL_W-1:0]    tail_val;
  logic [VAL_W-1:0]    pop_val;

  logic                rd_en, wr_en;
  logic [TALLY_AW-1:0] rd_addr;
  logic [TALLY_W-1:0]  rd_data, wr_data;

  logic [VAL_W-1:0]    in_val;
  logic                val_ok;
  logic                pop_ok;
  logic                dump_last;

  assign in_val    = in_data_i.item_value;
  assign val_ok    = ({1'b0, in_val} < VALUE_RANGE);
  assign tail_val  = cells[IDX_W'(count_q - CNT_W'(1))];
  assign out_free  = !out_valid_q || out_ready_i;
  assign dump_last = ((CNT_W'(dump_idx_q) + CNT_W'(1)) == count_q);

  assign chain_ctrl.op    = chain_op;
  assign chain_ctrl.value = in_val;
  assign chain_ctrl.count = count_q;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] prev_w, next_w;
    if (g == 0) begin : g_first
      assign prev_w = in_val;
    end else begin : g_inner_prev
      assign prev_w = cells[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_w = cells[g];
    end else begin : g_inner_next
      assign next_w = cells[g+1];
    end
    cdqm_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (chain_ctrl),
      .idx_i  (IDX_W'(g)),
      .prev_i (prev_w),
      .next_i (next_w),
      .head_i (cells[0]),
      .val_o  (cells[g])
    );
  end

  cdqm_tally u_tally (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_addr_q),
    .wr_data_i (wr_data)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    dump_idx_d   = dump_idx_q;
    res_status_d = res_status_q;
    cnt_inc_d    = cnt_inc_q;
    cnt_addr_d   = cnt_addr_q;
    chain_op     = CH_HOLD;
    rd_en        = 1'b0;
    rd_addr      = TALLY_AW'(in_val);
    wr_en        = 1'b0;
    wr_data      = rd_data;
    in_ready_o   = 1'b0;
    out_load     = 1'b0;
    out_next     = '0;
    pop_val      = cells[0];
    pop_ok       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_data_i.kind)
            KIND_INS_HEAD, KIND_INS_TAIL: begin
              if (val_ok) begin
                if (count_q == CNT_W'(DEPTH)) begin
                  res_status_d = STAT_FULL;
                  state_d      = ST_EMIT;
                end else begin
                  chain_op   = (in_data_i.kind == KIND_INS_HEAD) ? CH_PUSH_HEAD
                                                                 : CH_PUSH_TAIL;
                  count_d    = count_q + CNT_W'(1);
                  rd_en      = 1'b1;
                  cnt_addr_d = TALLY_AW'(in_val);
                  cnt_inc_d  = 1'b1;
                  state_d    = ST_CNT_UPD;
                end
              end
            end
            KIND_REM_HEAD, KIND_REM_TAIL: begin
              if (count_q != '0) begin
                if (in_data_i.kind == KIND_REM_HEAD) begin
                  chain_op = CH_POP_HEAD;
                  pop_val  = cells[0];
                end else begin
                  pop_val  = tail_val;
                end
                count_d = count_q - CNT_W'(1);
                pop_ok  = ({1'b0, pop_val} < VALUE_RANGE);
                if (pop_ok) begin
                  rd_en      = 1'b1;
                  rd_addr    = TALLY_AW'(pop_val);
                  cnt_addr_d = TALLY_AW'(pop_val);
                  cnt_inc_d  = 1'b0;
                  state_d    = ST_CNT_UPD;
                end
              end
            end
            KIND_SEARCH: begin
              if (count_q == '0) begin
                res_status_d = STAT_EMPTY;
                state_d      = ST_EMIT;
              end else if (!val_ok) begin
                res_status_d = STAT_MISSING;
                state_d      = ST_EMIT;
              end else begin
                rd_en   = 1'b1;
                state_d = ST_SEARCH;
              end
            end
            KIND_DUMP: begin
              if (count_q == '0) begin
                res_status_d = STAT_EMPTY;
                state_d      = ST_EMIT;
              end else begin
                dump_idx_d = '0;
                state_d    = ST_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CNT_UPD: begin
        wr_en = 1'b1;
        if (cnt_inc_q) begin
          wr_data = (rd_data != TALLY_MAX) ? rd_data + TALLY_W'(1) : rd_data;
        end else begin
          wr_data = (rd_data != '0) ? rd_data - TALLY_W'(1) : rd_data;
        end
        state_d = ST_IDLE;
      end
      ST_SEARCH: begin
        res_status_d = (rd_data != '0) ? STAT_FOUND : STAT_MISSING;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_next.status  = res_status_q;
          out_next.last    = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_next.status    = STAT_ELEMENT;
          out_next.out_value = cells[0];
          out_next.last      = dump_last;
          chain_op           = CH_ROTATE;
          dump_idx_d         = dump_idx_q + IDX_W'(1);
          if (dump_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      dump_idx_q <= dump_idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    cnt_inc_q    <= cnt_inc_d;
    cnt_addr_q   <= cnt_addr_d;
    if (out_load) out_data_q <= out_next;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> (count_q != '0) && (CNT_W'(dump_idx_q) < count_q))
    else $error("dump running past the occupied cells");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |=> (count_q == $past(count_q)))
    else $error("entry count changed outside idle");

endmodule

FILE: tb/sv/deque_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the deque, keeps its own copy of the ring and the
// occurrence table, and checks every result beat against the oldest
// predicted one.
module deque_result_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  cdqm_pkg::in_beat_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  cdqm_pkg::out_beat_t out_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o
);
  import cdqm_pkg::*;

  logic [VAL_W-1:0]   ring [DEPTH];
  logic [TALLY_W-1:0] tally [VALUE_RANGE];
  int unsigned        head;
  int unsigned        fill;
  out_beat_t          expected_beats [$];

  function automatic out_beat_t make_beat(logic [STAT_W-1:0] status,
                                          logic [VAL_W-1:0] value, logic last);
    out_beat_t b;
    b.status    = status;
    b.out_value = value;
    b.last      = last;
    return b;
  endfunction

  function automatic void tally_down(logic [VAL_W-1:0] v);
    if (v < VALUE_RANGE && tally[v] != '0) tally[v] = tally[v] - 1'b1;
  endfunction

  // Advances the shadow deque by one request and queues the beats it causes.
  function automatic void apply_request(in_beat_t req);
    int unsigned pos;
    case (req.kind)
      KIND_INS_HEAD, KIND_INS_TAIL: begin
        if (req.item_value < VALUE_RANGE) begin
          if (fill == DEPTH) begin
            expected_beats.push_back(make_beat(STAT_FULL, '0, 1'b1));
          end else begin
            if (req.kind == KIND_INS_HEAD) begin
              head = (head + DEPTH - 1) % DEPTH;
              pos  = head;
            end else begin
              pos = (head + fill) % DEPTH;
            end
            ring[pos] = req.item_value;
            fill++;
            if (tally[req.item_value] != TALLY_MAX)
              tally[req.item_value] = tally[req.item_value] + 1'b1;
          end
        end
      end
      KIND_REM_HEAD: begin
        if (fill != 0) begin
          tally_down(ring[head]);
          head = (head + 1) % DEPTH;
          fill--;
        end
      end
      KIND_REM_TAIL: begin
        if (fill != 0) begin
          tally_down(ring[(head + fill - 1) % DEPTH]);
          fill--;
        end
      end
      KIND_SEARCH: begin
        if (fill == 0)
          expected_beats.push_back(make_beat(STAT_EMPTY, '0, 1'b1));
        else if (req.item_value < VALUE_RANGE && tally[req.item_value] != '0)
          expected_beats.push_back(make_beat(STAT_FOUND, '0, 1'b1));
        else
          expected_beats.push_back(make_beat(STAT_MISSING, '0, 1'b1));
      end
      KIND_DUMP: begin
        if (fill == 0) begin
          expected_beats.push_back(make_beat(STAT_EMPTY, '0, 1'b1));
        end else begin
          for (int unsigned i = 0; i < fill; i++)
            expected_beats.push_back(make_beat(STAT_ELEMENT, ring[(head + i) % DEPTH],
                                               (i + 1 == fill)));
        end
      end
      default: ;  // spare kinds do nothing
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      for (int i = 0; i < VALUE_RANGE; i++) tally[i] = '0;
      head = 0;
      fill = 0;
      expected_beats.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: status %0d value %0d last %0b",
                 out_data_i.status, out_data_i.out_value, out_data_i.last);
          fail_count_o++;
        end else begin
          want = expected_beats.pop_front();
          if (out_data_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_i.status);
            fail_count_o++;
          end
          if (out_data_i.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d", want.out_value,
                   out_data_i.out_value);
            fail_count_o++;
          end
          if (out_data_i.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data_i.last);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) apply_request(in_data_i);
      pending_o = expected_beats.size();
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import cdqm_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned QUIET_TAIL   = 40;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  // kinds the block decodes as no-ops
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_beat_t   out_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  int unsigned cycles;
  int unsigned occupancy;
  int unsigned sent;
  int unsigned effective;
  int unsigned full_hits;
  bit          quiet;
  bit          hold_req;
  bit          hold_done;

  circular_deque_with_membership dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  deque_result_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i     = 1'b0;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
  end

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offers one request beat and holds it until accepted; random gap first.
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] value);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= '{kind: kind, item_value: value};
    do @(posedge clk_i); while (!in_ready);
    sent++;
    case (kind)
      KIND_INS_HEAD, KIND_INS_TAIL: begin
        if (value < VALUE_RANGE) begin
          effective++;
          if (occupancy == DEPTH) full_hits++;
          else occupancy++;
        end
      end
      KIND_REM_HEAD, KIND_REM_TAIL: begin
        if (occupancy != 0) begin
          effective++;
          occupancy--;
        end
      end
      KIND_SEARCH, KIND_DUMP: effective++;
      default: ;
    endcase
  endtask

  // mostly a narrow range so searches hit, now and then the full 7 bits
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return VAL_W'($urandom_range(0, 15));
    if (r < 9) return VAL_W'($urandom_range(0, VALUE_RANGE - 1));
    return VAL_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 18) return KIND_INS_HEAD;
    if (r < 36) return KIND_INS_TAIL;
    if (r < 49) return KIND_REM_HEAD;
    if (r < 62) return KIND_REM_TAIL;
    if (r < 84) return KIND_SEARCH;
    if (r < 94) return KIND_DUMP;
    if (r < 97) return KIND_SPARE_LO;
    return KIND_SPARE_HI;
  endfunction

  // receiver: bursts of stall and of ready, one long hold-off on request
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        repeat (LONG_HOLD) begin
          @(negedge clk_i);
          out_ready <= 1'b0;
        end
        hold_req  = 1'b0;
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 19);
        repeat (n) begin
          @(negedge clk_i);
          out_ready <= 1'b0;
        end
      end else begin
        n = $urandom_range(1, 19);
        repeat (n) begin
          @(negedge clk_i);
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int unsigned base;
    int unsigned drain_wait;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty cases, extremes of the value, spare kinds
    send_request(KIND_SEARCH, 7'd5);
    send_request(KIND_DUMP, 7'd0);
    send_request(KIND_REM_HEAD, 7'd0);
    send_request(KIND_REM_TAIL, 7'd127);
    send_request(KIND_INS_HEAD, 7'd0);
    send_request(KIND_INS_TAIL, 7'd99);
    send_request(KIND_INS_HEAD, 7'd127);   // outside the table: ignored
    send_request(KIND_INS_TAIL, 7'd100);   // outside the table: ignored
    send_request(KIND_SEARCH, 7'd0);
    send_request(KIND_SEARCH, 7'd99);
    send_request(KIND_SEARCH, 7'd50);
    send_request(KIND_SEARCH, 7'd127);
    send_request(KIND_SPARE_LO, 7'd42);
    send_request(KIND_SPARE_HI, 7'd127);
    send_request(KIND_INS_HEAD, 7'd99);    // duplicate value
    send_request(KIND_DUMP, 7'd127);
    send_request(KIND_REM_HEAD, 7'd0);
    send_request(KIND_SEARCH, 7'd99);      // one copy still held
    send_request(KIND_REM_TAIL, 7'd0);
    send_request(KIND_SEARCH, 7'd99);
    send_request(KIND_DUMP, 7'd0);
    send_request(KIND_REM_TAIL, 7'd0);
    send_request(KIND_DUMP, 7'd0);

    base = effective;
    while (effective - base < RANDOM_ITEMS) begin
      if (!hold_done && !hold_req && effective - base >= 100) begin
        hold_req = 1'b1;
        repeat (12) send_request(KIND_SEARCH, pick_value());
      end
      if (effective - base + QUIET_TAIL >= RANDOM_ITEMS) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0, 1: begin
          // fill to the brim, overflow, then dump the full ring
          while (occupancy < DEPTH)
            send_request($urandom_range(0, 1) ? KIND_INS_HEAD : KIND_INS_TAIL,
                         VAL_W'($urandom_range(0, VALUE_RANGE - 1)));
          repeat ($urandom_range(1, 2))
            send_request($urandom_range(0, 1) ? KIND_INS_HEAD : KIND_INS_TAIL,
                         pick_value());
          send_request(KIND_DUMP, pick_value());
        end
        2: begin
          while (occupancy > 0)
            send_request($urandom_range(0, 1) ? KIND_REM_HEAD : KIND_REM_TAIL, pick_value());
          send_request($urandom_range(0, 1) ? KIND_REM_HEAD : KIND_REM_TAIL, pick_value());
          send_request(KIND_SEARCH, pick_value());
        end
        default: send_request(pick_kind(), pick_value());
      endcase
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    drain_wait = DRAIN_CYCLES;
    repeat (drain_wait) @(negedge clk_i);

    $display("%0d request beats sent, %0d with effect; %0d result beats checked",
             sent, effective, checked);
    $display("ring overflowed %0d times; long output hold-off %s",
             full_hits, hold_done ? "done" : "not reached");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
